[rtl/bop_pkg.sv]
// Shared types, constants and fixed-point helpers for the binomial option pricer.
// Used by the controller, the datapath and the top level; depends on nothing.
package bop_pkg;

  localparam logic [31:0] ONE_Q30 = 32'h4000_0000;
  localparam int StepW = 11;

  typedef enum logic [1:0] {
    ST_TREE    = 2'd0,
    ST_INVALID = 2'd1,
    ST_EXPIRY  = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_PW_INIT,
    OP_PW_MUL,
    OP_PW_WR,
    OP_RD,
    OP_MUL1,
    OP_MUL2,
    OP_WR
  } op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_PW_MUL,
    S_PW_WR,
    S_PRE,
    S_RD,
    S_MUL1,
    S_MUL2,
    S_WR,
    S_FIN
  } state_e;

  typedef struct packed {
    op_e     op;
    logic    leaf;
    logic    first;
    logic    out_load;
    status_e out_sel;
  } cmd_t;

  typedef struct packed {
    logic             bad;
    logic             expiry;
    logic [StepW-1:0] steps;
  } stat_t;

  // Combines the two partial products of a 64 by 32 Q2.30 multiply, saturating.
  function automatic logic [63:0] mulq30_sat(input logic [63:0] hi_prod,
                                             input logic [63:0] lo_prod);
    logic [64:0] sum;
    sum = {1'b0, hi_prod[61:0], 2'b00} + {31'b0, lo_prod[63:30]};
    if (hi_prod > 64'h3FFF_FFFF_FFFF_FFFF) begin
      return '1;
    end
    if (sum[64]) begin
      return '1;
    end
    return sum[63:0];
  endfunction

  function automatic logic [31:0] sat32(input logic [63:0] v);
    if (v[63:32] != 32'd0) begin
      return '1;
    end
    return v[31:0];
  endfunction

  function automatic logic [31:0] payoff(input logic [31:0] s, input logic [31:0] k,
                                         input logic call);
    if (call) begin
      return (s > k) ? s - k : 32'd0;
    end
    return (k > s) ? k - s : 32'd0;
  endfunction

endpackage

[rtl/binomial_option_pricer_top.sv]
// Binomial option pricer: one option request in, one price out, using a
// recombining Cox-Ross-Rubinstein tree with host-supplied factors, Q16.16 prices
// and Q2.30 factors. An accepted request first builds the up and down power
// tables, each entry through a multiply state and a write state, then passes every
// tree node through the read, multiply and write states of the single node
// pipeline around the node-value RAM, with a preparatory state before each level.
// Invalid and at-expiry requests skip the tree. A new request is taken once the
// previous one has been priced, while its result may still wait in the output
// register. Depends on bop_pkg, bop_ctrl, bop_dp and bop_ram.
module binomial_option_pricer_top #(
  parameter int MAX_STEPS = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] spot_i,
  input  logic [31:0] strike_i,
  input  logic [31:0] up_factor_i,
  input  logic [31:0] down_factor_i,
  input  logic [30:0] up_probability_i,
  input  logic [30:0] discount_i,
  input  logic [10:0] step_count_i,
  input  logic        is_call_i,
  input  logic        is_american_i,
  input  logic        at_expiry_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] price_o,
  output logic [1:0]  status_o
);
  import bop_pkg::*;

  localparam int AW = $clog2(MAX_STEPS + 1);

  cmd_t          cmd;
  stat_t         stat;
  logic [AW-1:0] idx, lvl;

  bop_ctrl #(.MAX_STEPS(MAX_STEPS), .AW(AW)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .idx_o       (idx),
    .lvl_o       (lvl)
  );

  bop_dp #(.MAX_STEPS(MAX_STEPS), .AW(AW)) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .idx_i            (idx),
    .lvl_i            (lvl),
    .stat_o           (stat),
    .spot_i           (spot_i),
    .strike_i         (strike_i),
    .up_factor_i      (up_factor_i),
    .down_factor_i    (down_factor_i),
    .up_probability_i (up_probability_i),
    .discount_i       (discount_i),
    .step_count_i     (step_count_i),
    .is_call_i        (is_call_i),
    .is_american_i    (is_american_i),
    .at_expiry_i      (at_expiry_i),
    .price_o          (price_o),
    .status_o         (status_o)
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready stayed high after a request was accepted");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_INVALID) |-> price_o == 32'd0)
    else $error("invalid request produced a nonzero price");

  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared without a request in progress");

endmodule

[rtl/bop_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; used for the power tables and the node values.
module bop_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1025,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/bop_dp.sv]
// Datapath of the binomial option pricer: input registers, power chains,
// node arithmetic and the result register. Depends on bop_pkg and bop_ram.
module bop_dp #(
  parameter int MAX_STEPS = 1024,
  parameter int AW        = $clog2(MAX_STEPS + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  bop_pkg::cmd_t         cmd_i,
  input  logic [AW-1:0]         idx_i,
  input  logic [AW-1:0]         lvl_i,
  output bop_pkg::stat_t        stat_o,
  input  logic [31:0]           spot_i,
  input  logic [31:0]           strike_i,
  input  logic [31:0]           up_factor_i,
  input  logic [31:0]           down_factor_i,
  input  logic [30:0]           up_probability_i,
  input  logic [30:0]           discount_i,
  input  logic [10:0]           step_count_i,
  input  logic                  is_call_i,
  input  logic                  is_american_i,
  input  logic                  at_expiry_i,
  output logic [31:0]           price_o,
  output logic [1:0]            status_o
);
  import bop_pkg::*;

  localparam int Depth = MAX_STEPS + 1;

  logic [31:0] s_q, k_q, u_q, d_q;
  logic [30:0] p_q, df_q;
  logic [10:0] n_q;
  logic        call_q, amer_q, expiry_q;

  logic [30:0] p_sat, q_sat, df_sat;

  logic [63:0] a_q, ph_q, pl_q, pb_q;
  logic [31:0] b_q;
  logic [63:0] a_next;
  logic [31:0] b_next;

  logic [31:0] cur_q, nxt_q, e_q, ex_q, res_q, price_q;
  logic [62:0] pv_q, qv_q;
  logic [63:0] sh_q, sl_q;
  status_e     status_q;
  logic [63:0] esum;
  logic [62:0] cprod;
  logic [31:0] cont, wval;

  logic          pw_we;
  logic [AW-1:0] pw_waddr;
  logic [63:0]   up_wdata, up_rdata;
  logic [31:0]   dn_wdata, dn_rdata, v_rdata;
  logic [AW-1:0] v_raddr;

  assign p_sat  = (p_q > 31'(ONE_Q30)) ? 31'(ONE_Q30) : p_q;
  assign q_sat  = 31'(ONE_Q30) - p_sat;
  assign df_sat = (df_q > 31'(ONE_Q30)) ? 31'(ONE_Q30) : df_q;

  assign stat_o.bad    = (s_q == 32'd0) || (k_q == 32'd0) || (n_q == 11'd0) ||
                         (32'(n_q) > 32'(MAX_STEPS));
  assign stat_o.expiry = expiry_q;
  assign stat_o.steps  = n_q;

  assign a_next = mulq30_sat(ph_q, pl_q);
  assign b_next = sat32({30'd0, pb_q[63:30]});

  assign pw_we    = (cmd_i.op == OP_PW_INIT) || (cmd_i.op == OP_PW_WR);
  assign pw_waddr = (cmd_i.op == OP_PW_INIT) ? '0 : idx_i;
  assign up_wdata = (cmd_i.op == OP_PW_INIT) ? {32'd0, s_q} : a_next;
  assign dn_wdata = (cmd_i.op == OP_PW_INIT) ? ONE_Q30 : b_next;
  assign v_raddr  = (cmd_i.op == OP_RD && !cmd_i.leaf) ? idx_i + AW'(1) : '0;

  assign esum  = {1'b0, pv_q} + {1'b0, qv_q};
  assign cprod = e_q * df_sat;
  assign cont  = cprod[61:30];
  always_comb begin
    if (cmd_i.leaf) begin
      wval = ex_q;
    end else if (amer_q && (ex_q > cont)) begin
      wval = ex_q;
    end else begin
      wval = cont;
    end
  end

  bop_ram #(.WIDTH(64), .DEPTH(Depth), .AW(AW)) u_up_ram (
    .clk_i   (clk_i),
    .we_i    (pw_we),
    .waddr_i (pw_waddr),
    .wdata_i (up_wdata),
    .raddr_i (lvl_i - idx_i),
    .rdata_o (up_rdata)
  );

  bop_ram #(.WIDTH(32), .DEPTH(Depth), .AW(AW)) u_dn_ram (
    .clk_i   (clk_i),
    .we_i    (pw_we),
    .waddr_i (pw_waddr),
    .wdata_i (dn_wdata),
    .raddr_i (idx_i),
    .rdata_o (dn_rdata)
  );

  bop_ram #(.WIDTH(32), .DEPTH(Depth), .AW(AW)) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.op == OP_WR),
    .waddr_i (idx_i),
    .wdata_i (wval),
    .raddr_i (v_raddr),
    .rdata_o (v_rdata)
  );

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        s_q      <= spot_i;
        k_q      <= strike_i;
        u_q      <= up_factor_i;
        d_q      <= down_factor_i;
        p_q      <= up_probability_i;
        df_q     <= discount_i;
        n_q      <= step_count_i;
        call_q   <= is_call_i;
        amer_q   <= is_american_i;
        expiry_q <= at_expiry_i;
      end
      OP_PW_INIT: begin
        a_q <= {32'd0, s_q};
        b_q <= ONE_Q30;
      end
      OP_PW_MUL: begin
        ph_q <= a_q[63:32] * u_q;
        pl_q <= a_q[31:0] * u_q;
        pb_q <= b_q * d_q;
      end
      OP_PW_WR: begin
        a_q <= a_next;
        b_q <= b_next;
      end
      OP_RD: begin
        if (cmd_i.first) begin
          cur_q <= v_rdata;
        end
      end
      OP_MUL1: begin
        nxt_q <= v_rdata;
        pv_q  <= p_sat * cur_q;
        qv_q  <= q_sat * v_rdata;
        sh_q  <= up_rdata[63:32] * dn_rdata;
        sl_q  <= up_rdata[31:0] * dn_rdata;
      end
      OP_MUL2: begin
        e_q  <= esum[61:30];
        ex_q <= payoff(sat32(mulq30_sat(sh_q, sl_q)), k_q, call_q);
      end
      OP_WR: begin
        cur_q <= nxt_q;
        res_q <= wval;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q <= ST_TREE;
    end else if (cmd_i.out_load) begin
      status_q <= cmd_i.out_sel;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      case (cmd_i.out_sel)
        ST_INVALID: price_q <= 32'd0;
        ST_EXPIRY:  price_q <= payoff(s_q, k_q, call_q);
        default:    price_q <= res_q;
      endcase
    end
  end

  assign price_o  = price_q;
  assign status_o = status_q;

endmodule

[rtl/bop_ctrl.sv]
// Controller of the binomial option pricer: sequences the power chains,
// the leaf level and the backward induction. Depends on bop_pkg.
module bop_ctrl #(
  parameter int MAX_STEPS = 1024,
  parameter int AW        = $clog2(MAX_STEPS + 1)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  bop_pkg::stat_t stat_i,
  output bop_pkg::cmd_t  cmd_o,
  output logic [AW-1:0]  idx_o,
  output logic [AW-1:0]  lvl_o
);
  import bop_pkg::*;

  state_e        state_q, state_d;
  logic [AW-1:0] i_q, i_d, j_q, j_d;
  logic          leaf_q, leaf_d;
  status_e       sel_q, sel_d;
  logic          out_valid_q, out_valid_d;
  logic [AW+StepW-1:0] n_ext;
  logic [AW-1:0] n_cnt;

  assign n_ext = {{AW{1'b0}}, stat_i.steps};
  assign n_cnt = n_ext[AW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      i_q         <= '0;
      j_q         <= '0;
      leaf_q      <= 1'b0;
      sel_q       <= ST_TREE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      i_q         <= i_d;
      j_q         <= j_d;
      leaf_q      <= leaf_d;
      sel_q       <= sel_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    i_d          = i_q;
    j_d          = j_q;
    leaf_d       = leaf_q;
    sel_d        = sel_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    in_ready_o   = 1'b0;
    cmd_o.op       = OP_NONE;
    cmd_o.leaf     = leaf_q;
    cmd_o.first    = (i_q == '0);
    cmd_o.out_load = 1'b0;
    cmd_o.out_sel  = sel_q;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat_i.bad) begin
          sel_d   = ST_INVALID;
          state_d = S_FIN;
        end else if (stat_i.expiry) begin
          sel_d   = ST_EXPIRY;
          state_d = S_FIN;
        end else begin
          sel_d    = ST_TREE;
          cmd_o.op = OP_PW_INIT;
          i_d      = AW'(1);
          state_d  = S_PW_MUL;
        end
      end
      S_PW_MUL: begin
        cmd_o.op = OP_PW_MUL;
        state_d  = S_PW_WR;
      end
      S_PW_WR: begin
        cmd_o.op = OP_PW_WR;
        if (i_q == n_cnt) begin
          j_d     = n_cnt;
          i_d     = '0;
          leaf_d  = 1'b1;
          state_d = S_PRE;
        end else begin
          i_d     = i_q + AW'(1);
          state_d = S_PW_MUL;
        end
      end
      S_PRE: begin
        state_d = S_RD;
      end
      S_RD: begin
        cmd_o.op = OP_RD;
        state_d  = S_MUL1;
      end
      S_MUL1: begin
        cmd_o.op = OP_MUL1;
        state_d  = S_MUL2;
      end
      S_MUL2: begin
        cmd_o.op = OP_MUL2;
        state_d  = S_WR;
      end
      S_WR: begin
        cmd_o.op = OP_WR;
        if (i_q == j_q) begin
          if (j_q == '0) begin
            state_d = S_FIN;
          end else begin
            j_d     = j_q - AW'(1);
            i_d     = '0;
            leaf_d  = 1'b0;
            state_d = S_PRE;
          end
        end else begin
          i_d     = i_q + AW'(1);
          state_d = S_RD;
        end
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign idx_o       = i_q;
  assign lvl_o       = j_q;

endmodule

[tb/tb_binomial_option_pricer_top.sv]
// Self-checking testbench for binomial_option_pricer_top: directed option requests, then
// random ones, compared at the output with a table price or an in-bench binomial tree.
// Depends on bop_pkg and the pricer RTL.
module tb_binomial_option_pricer_top;
  import bop_pkg::*;

  localparam int MaxSteps = 1024;
  localparam int NumRandom = 80;

  typedef struct {
    logic [31:0] spot;
    logic [31:0] strike;
    logic [31:0] up;
    logic [31:0] dn;
    logic [30:0] prob;
    logic [30:0] disc;
    logic [10:0] steps;
    logic        call;
    logic        amer;
    logic        expiry;
    logic        typed;
    logic [31:0] price;
    status_e     status;
  } option_t;

  typedef struct {
    logic [31:0] price;
    status_e     status;
  } quote_t;

  localparam logic [31:0] Max32 = 32'hFFFF_FFFF;
  localparam logic [31:0] OneQ = 32'h4000_0000;
  localparam logic [31:0] UpQ = 32'h4200_0000;
  localparam logic [31:0] DnQ = 32'h3E0F_83E1;

  localparam int NumDirected = 21;
  option_t dir_tbl [NumDirected] = '{
    '{32'h0, 32'h10000, UpQ, DnQ, 31'h2000_0000, 31'h3FFF_0000, 11'd4, 1, 0, 0,
      1, 32'd0, ST_INVALID},
    '{32'h10000, 32'h0, UpQ, DnQ, 31'h2000_0000, 31'h3FFF_0000, 11'd4, 0, 1, 0,
      1, 32'd0, ST_INVALID},
    '{32'h10000, 32'h10000, UpQ, DnQ, 31'h2000_0000, 31'h3FFF_0000, 11'd0, 1, 1, 0,
      1, 32'd0, ST_INVALID},
    '{32'h10000, 32'h10000, UpQ, DnQ, 31'h2000_0000, 31'h3FFF_0000, 11'd1025, 1, 0, 0,
      1, 32'd0, ST_INVALID},
    '{32'h10000, 32'h10000, UpQ, DnQ, 31'h2000_0000, 31'h3FFF_0000, 11'h7FF, 0, 0, 1,
      1, 32'd0, ST_INVALID},
    '{32'h0, 32'h10000, UpQ, DnQ, 31'h2000_0000, 31'h3FFF_0000, 11'd4, 1, 0, 1,
      1, 32'd0, ST_INVALID},
    '{Max32, 32'h1, UpQ, DnQ, 31'h2000_0000, 31'h3FFF_0000, 11'd4, 1, 0, 1,
      1, 32'hFFFF_FFFE, ST_EXPIRY},
    '{32'h1, Max32, UpQ, DnQ, 31'h2000_0000, 31'h3FFF_0000, 11'd4, 0, 1, 1,
      1, 32'hFFFF_FFFE, ST_EXPIRY},
    '{32'h1, Max32, UpQ, DnQ, 31'h2000_0000, 31'h3FFF_0000, 11'd4, 1, 0, 1,
      1, 32'd0, ST_EXPIRY},
    '{32'h64_0000, 32'h64_0000, UpQ, DnQ, 31'h2000_0000, 31'h3FFF_0000, 11'd1, 1, 0, 0,
      0, 32'd0, ST_TREE},
    '{32'h64_0000, 32'h6E_0000, UpQ, DnQ, 31'h2000_0000, 31'h3FFF_0000, 11'd5, 0, 1, 0,
      0, 32'd0, ST_TREE},
    '{32'h64_0000, 32'h5A_0000, UpQ, DnQ, 31'h7FFF_FFFF, 31'h3FFF_0000, 11'd6, 1, 0, 0,
      0, 32'd0, ST_TREE},
    '{32'h64_0000, 32'h5A_0000, UpQ, DnQ, 31'h2000_0000, 31'h7FFF_FFFF, 11'd6, 0, 1, 0,
      0, 32'd0, ST_TREE},
    '{Max32, 32'h1, Max32, Max32, 31'h4000_0000, 31'h4000_0000, 11'd8, 1, 1, 0,
      0, 32'd0, ST_TREE},
    '{Max32, Max32, Max32, 32'h0, 31'h0, 31'h0, 11'd3, 0, 0, 0,
      0, 32'd0, ST_TREE},
    '{32'h1, Max32, 32'h0, 32'h0, 31'h4000_0000, 31'h4000_0000, 11'd7, 0, 1, 0,
      0, 32'd0, ST_TREE},
    '{Max32, 32'h1, Max32, Max32, 31'h0, 31'h4000_0000, 11'd2, 0, 0, 0,
      0, 32'd0, ST_TREE},
    '{32'hFFFF_0000, 32'h8000_0000, OneQ, OneQ, 31'h1555_5555, 31'h3FFF_FFFF, 11'd9, 1, 1,
      0, 0, 32'd0, ST_TREE},
    '{32'h64_0000, 32'h64_0000, 32'h4010_0000, 32'h3FF0_03FF, 31'h2000_0000,
      31'h3FFF_F000, 11'd1024, 0, 1, 0, 0, 32'd0, ST_TREE},
    '{32'h64_0000, 32'h64_0000, 32'h4010_0000, 32'h3FF0_03FF, 31'h2000_0000,
      31'h3FFF_F000, 11'd40, 1, 0, 0, 0, 32'd0, ST_TREE},
    '{32'h64_0000, 32'h64_0000, UpQ, DnQ, 31'h2000_0000, 31'h3FFF_0000, 11'd1024, 1, 0, 1,
      1, 32'd0, ST_EXPIRY}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [31:0] spot_i;
  logic [31:0] strike_i;
  logic [31:0] up_factor_i;
  logic [31:0] down_factor_i;
  logic [30:0] up_probability_i;
  logic [30:0] discount_i;
  logic [10:0] step_count_i;
  logic        is_call_i;
  logic        is_american_i;
  logic        at_expiry_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [31:0] price_o;
  logic [1:0]  status_o;

  quote_t pending_quotes[$];
  int     mismatches;
  int     send_idle_pct;
  int     recv_idle_pct;

  logic [63:0] spot_chain[MaxSteps + 1];
  logic [31:0] down_chain[MaxSteps + 1];
  logic [31:0] level_vals[MaxSteps + 1];

  binomial_option_pricer_top dut (.*);

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  function automatic logic [63:0] scale_q30(input logic [63:0] a, input logic [31:0] b);
    logic [95:0] prod;
    prod = ({32'd0, a} * {64'd0, b}) >> 30;
    return (prod[95:64] != 32'd0) ? 64'hFFFF_FFFF_FFFF_FFFF : prod[63:0];
  endfunction

  function automatic logic [31:0] clip32(input logic [63:0] v);
    return (v[63:32] != 32'd0) ? Max32 : v[31:0];
  endfunction

  function automatic logic [31:0] intrinsic(input logic [31:0] s, input logic [31:0] k,
                                            input logic call);
    if (call) begin
      return (s > k) ? s - k : 32'd0;
    end
    return (k > s) ? k - s : 32'd0;
  endfunction

  function automatic quote_t price_option(input option_t o);
    quote_t      q;
    logic [63:0] p;
    logic [63:0] df;
    logic [63:0] e;
    logic [31:0] cont;
    logic [31:0] ex;
    logic [31:0] s;
    int          n;
    n = o.steps;
    if (o.spot == 0 || o.strike == 0 || n == 0 || n > MaxSteps) begin
      q.price = 32'd0;
      q.status = ST_INVALID;
      return q;
    end
    if (o.expiry) begin
      q.price = intrinsic(o.spot, o.strike, o.call);
      q.status = ST_EXPIRY;
      return q;
    end
    p = (o.prob > OneQ) ? 64'(OneQ) : 64'(o.prob);
    df = (o.disc > OneQ) ? 64'(OneQ) : 64'(o.disc);
    spot_chain[0] = 64'(o.spot);
    down_chain[0] = OneQ;
    for (int i = 1; i <= n; i++) begin
      spot_chain[i] = scale_q30(spot_chain[i-1], o.up);
      down_chain[i] = clip32(scale_q30(64'(down_chain[i-1]), o.dn));
    end
    for (int i = 0; i <= n; i++) begin
      s = clip32(scale_q30(spot_chain[n-i], down_chain[i]));
      level_vals[i] = intrinsic(s, o.strike, o.call);
    end
    for (int j = n - 1; j >= 0; j--) begin
      for (int i = 0; i <= j; i++) begin
        e = (p * level_vals[i] + (64'(OneQ) - p) * level_vals[i+1]) >> 30;
        cont = 32'((e * df) >> 30);
        if (o.amer) begin
          s = clip32(scale_q30(spot_chain[j-i], down_chain[i]));
          ex = intrinsic(s, o.strike, o.call);
          level_vals[i] = (ex > cont) ? ex : cont;
        end else begin
          level_vals[i] = cont;
        end
      end
    end
    q.price = level_vals[0];
    q.status = ST_TREE;
    return q;
  endfunction

  function automatic option_t random_option();
    option_t o;
    int      kind;
    o.typed = 1'b0;
    o.price = '0;
    o.status = ST_TREE;
    kind = $urandom_range(0, 99);
    o.spot = (kind < 5) ? 32'd0 : $urandom_range(32'h1_0000, 32'hC8_0000);
    o.strike = o.spot + $urandom_range(0, 32'h40_0000) - 32'h20_0000;
    o.up = OneQ + $urandom_range(0, 32'h0400_0000);
    o.dn = 32'((64'h1 << 60) / o.up);
    o.prob = 31'($urandom_range(0, OneQ));
    o.disc = 31'($urandom_range(32'h3F00_0000, OneQ));
    o.steps = 11'($urandom_range(1, 12));
    if (kind >= 85) begin
      o.steps = 11'($urandom_range(13, 48));
    end
    o.call = 1'($urandom);
    o.amer = 1'($urandom);
    o.expiry = ($urandom_range(0, 9) == 0);
    if (kind >= 95) begin
      o.spot = $urandom;
      o.strike = $urandom;
      o.up = $urandom;
      o.dn = $urandom;
      o.prob = 31'($urandom);
      o.disc = 31'($urandom);
      o.steps = ($urandom_range(0, 1) == 0) ? 11'($urandom_range(1025, 2047)) :
                                               11'($urandom_range(0, 6));
    end
    return o;
  endfunction

  task automatic send_request(input option_t o);
    quote_t q;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    spot_i <= o.spot;
    strike_i <= o.strike;
    up_factor_i <= o.up;
    down_factor_i <= o.dn;
    up_probability_i <= o.prob;
    discount_i <= o.disc;
    step_count_i <= o.steps;
    is_call_i <= o.call;
    is_american_i <= o.amer;
    at_expiry_i <= o.expiry;
    do @(posedge clk_i); while (!in_ready_o);
    if (o.typed) begin
      q.price = o.price;
      q.status = o.status;
    end else begin
      q = price_option(o);
    end
    pending_quotes.push_back(q);
  endtask

  task automatic drain_quotes();
    in_valid_i <= 1'b0;
    while (pending_quotes.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    quote_t q;
    out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_quotes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result: price %h status %0d", price_o, status_o);
        end
      end else begin
        q = pending_quotes.pop_front();
        if (price_o !== q.price || status_o !== q.status) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected price %h status %0d, got price %h status %0d",
                     q.price, q.status, price_o, status_o);
          end
        end
      end
    end
  end

  initial begin
    #80_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    mismatches = 0;
    send_idle_pct = 7;
    recv_idle_pct = 54;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    out_ready_i = 1'b0;
    spot_i = '0;
    strike_i = '0;
    up_factor_i = '0;
    down_factor_i = '0;
    up_probability_i = '0;
    discount_i = '0;
    step_count_i = '0;
    is_call_i = 1'b0;
    is_american_i = 1'b0;
    at_expiry_i = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int i = 0; i < NumDirected; i++) begin
      send_request(dir_tbl[i]);
    end
    drain_quotes();
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 7 : (phase == 1) ? 54 : 0;
      recv_idle_pct = (phase == 0) ? 54 : (phase == 1) ? 7 : 0;
      for (int i = 0; i < NumRandom / 3 + 1; i++) begin
        send_request(random_option());
      end
      drain_quotes();
    end
    repeat (50) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
